>>> rtl/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
// Used by rrts_cell and round_robin_task_scheduler; depends on nothing.
package rrts_pkg;

    localparam logic [31:0] IDENT_MAX   = 32'hFFFF_FFFF;
    localparam logic [31:0] IDENT_FIRST = 32'd1;
    localparam logic [31:0] IDENT_START = 32'd2;

    localparam logic [1:0] WK_NONE  = 2'd0;
    localparam logic [1:0] WK_INPUT = 2'd1;
    localparam logic [1:0] WK_TIMER = 2'd2;
    localparam logic [1:0] WK_CHILD = 2'd3;

    typedef enum logic [1:0] {
        SLOT_ZOMBIE  = 2'd0,
        SLOT_READY   = 2'd1,
        SLOT_RUNNING = 2'd2,
        SLOT_BLOCKED = 2'd3
    } slot_status_t;

    typedef enum logic [2:0] {
        ACT_CREATE     = 3'd0,
        ACT_BLOCK      = 3'd1,
        ACT_BLOCK_CHAN = 3'd2,
        ACT_WAKE_CHAN  = 3'd3,
        ACT_WAKE_INPUT = 3'd4,
        ACT_TERMINATE  = 3'd5,
        ACT_SCHEDULE   = 3'd6
    } action_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SCAN,
        OP_NEW,
        OP_BLOCK,
        OP_BLOCK_CHAN,
        OP_WAKE_CHAN,
        OP_WAKE_INPUT,
        OP_TERMINATE,
        OP_PREP,
        OP_RUN,
        OP_RESTORE
    } cell_op_t;

    typedef enum logic [1:0] {
        SK_FREE,
        SK_CHAN,
        SK_READY
    } scan_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_EXEC,
        ST_DONE
    } fsm_state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  wait_kind;
        logic [63:0] wake_value;
        logic [15:0] channel_id;
        logic        wake_all;
        logic [63:0] exit_id;
        logic [63:0] now_tick;
    } req_word_t;

    typedef struct packed {
        logic [3:0]  slot_index;
        logic [31:0] task_ident;
        logic        success;
        logic [3:0]  running_slot;
        logic        resched_pending;
    } rsp_word_t;

    // Broadcast to every cell each cycle.
    typedef struct packed {
        cell_op_t    op;
        scan_kind_t  scan_kind;
        logic [1:0]  wait_kind;
        logic [63:0] wake_value;
        logic [15:0] channel;
        logic        wake_all;
        logic [63:0] exit_id;
        logic [63:0] now_tick;
        logic [31:0] new_ident;
        logic [31:0] cur_ident;
    } cell_cmd_t;

    // Best candidate so far; key low bits carry the task ident.
    typedef struct packed {
        logic        found;
        logic [32:0] key;
    } carry_t;

endpackage

>>> rtl/rrts_cell.sv
// One task slot of the scheduler, with its stage of the search chain.
// Depends on rrts_pkg.
module rrts_cell import rrts_pkg::*; #(
    parameter int SLOTS = 16,
    parameter int INDEX = 0,
    localparam int IW = $clog2(SLOTS)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cell_cmd_t      cmd,
    input  logic           sel,
    input  logic           is_cur,
    input  logic           scan_en,
    input  carry_t         carry_in,
    input  logic [IW-1:0]  idx_in,
    output carry_t         carry_out,
    output logic [IW-1:0]  idx_out,
    output logic [31:0]    ident
);

    slot_status_t  status_reg, status_next;
    logic [31:0]   ident_reg, ident_next;
    logic [1:0]    kind_reg, kind_next;
    logic [63:0]   wake_reg, wake_next;
    logic [15:0]   chan_reg, chan_next;
    carry_t        carry_reg, carry_next;
    logic [IW-1:0] cidx_reg, cidx_next;

    logic        timer_hit;
    logic        chan_hit;
    logic        match;
    logic [32:0] key;

    always_comb
    begin
        timer_hit = (status_reg == SLOT_BLOCKED) && (kind_reg == WK_TIMER) &&
                    (cmd.now_tick >= wake_reg);
        chan_hit  = (status_reg == SLOT_BLOCKED) && (chan_reg == cmd.channel);

        status_next = status_reg;
        ident_next  = ident_reg;
        kind_next   = kind_reg;
        wake_next   = wake_reg;
        chan_next   = chan_reg;

        case (cmd.op)
            OP_NEW:
            begin
                if (sel)
                begin
                    ident_next  = cmd.new_ident;
                    status_next = SLOT_READY;
                    kind_next   = WK_NONE;
                    wake_next   = '0;
                    chan_next   = '0;
                end
            end
            OP_BLOCK:
            begin
                if (is_cur)
                begin
                    kind_next   = cmd.wait_kind;
                    wake_next   = cmd.wake_value;
                    status_next = SLOT_BLOCKED;
                end
            end
            OP_BLOCK_CHAN:
            begin
                if (is_cur)
                begin
                    chan_next   = cmd.channel;
                    status_next = SLOT_BLOCKED;
                end
            end
            OP_WAKE_CHAN:
            begin
                if (cmd.wake_all ? chan_hit : sel)
                begin
                    chan_next   = '0;
                    status_next = SLOT_READY;
                end
            end
            OP_WAKE_INPUT:
            begin
                if (status_reg == SLOT_BLOCKED && kind_reg == WK_INPUT)
                begin
                    kind_next   = WK_NONE;
                    status_next = SLOT_READY;
                end
            end
            OP_TERMINATE:
            begin
                // the exiting task turns zombie before waiters are checked
                if (is_cur)
                    status_next = SLOT_ZOMBIE;
                else if (status_reg == SLOT_BLOCKED && kind_reg == WK_CHILD &&
                         wake_reg == cmd.exit_id)
                begin
                    kind_next   = WK_NONE;
                    status_next = SLOT_READY;
                end
            end
            OP_PREP:
            begin
                if (timer_hit)
                begin
                    kind_next   = WK_NONE;
                    status_next = SLOT_READY;
                end
                else if (is_cur)
                begin
                    if (status_reg == SLOT_RUNNING)
                        status_next = SLOT_READY;
                end
                else if (status_reg == SLOT_ZOMBIE && ident_reg != '0)
                begin
                    // reap: wipe the slot
                    ident_next = '0;
                    kind_next  = WK_NONE;
                    wake_next  = '0;
                    chan_next  = '0;
                end
            end
            OP_RUN:
            begin
                if (sel)
                    status_next = SLOT_RUNNING;
            end
            OP_RESTORE:
            begin
                if (is_cur && status_reg != SLOT_ZOMBIE)
                    status_next = SLOT_RUNNING;
            end
            default:
            begin
            end
        endcase
    end

    // Search stage: keep the smaller key, first one wins ties.
    always_comb
    begin
        case (cmd.scan_kind)
            SK_FREE:
            begin
                match = (ident_reg == '0);
                key   = '0;
            end
            SK_CHAN:
            begin
                match = chan_hit;
                key   = {1'b0, ident_reg};
            end
            default:
            begin
                // tasks after the current one come first, then wrap around
                match = (status_reg == SLOT_READY);
                key   = {(ident_reg <= cmd.cur_ident), ident_reg};
            end
        endcase

        carry_next = carry_reg;
        cidx_next  = cidx_reg;
        if (scan_en)
        begin
            if (match && (!carry_in.found || key < carry_in.key))
            begin
                carry_next.found = 1'b1;
                carry_next.key   = key;
                cidx_next        = IW'(INDEX);
            end
            else
            begin
                carry_next = carry_in;
                cidx_next  = idx_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= (INDEX == 0) ? SLOT_RUNNING : SLOT_ZOMBIE;
            ident_reg  <= (INDEX == 0) ? IDENT_FIRST : '0;
            kind_reg   <= WK_NONE;
            wake_reg   <= '0;
            chan_reg   <= '0;
            carry_reg  <= '0;
            cidx_reg   <= '0;
        end
        else
        begin
            status_reg <= status_next;
            ident_reg  <= ident_next;
            kind_reg   <= kind_next;
            wake_reg   <= wake_next;
            chan_reg   <= chan_next;
            carry_reg  <= carry_next;
            cidx_reg   <= cidx_next;
        end
    end

    assign carry_out = carry_reg;
    assign idx_out   = cidx_reg;
    assign ident     = ident_reg;

endmodule

>>> rtl/round_robin_task_scheduler.sv
// Round-robin task scheduler: a row of slot cells and the sequencer.
// Create, channel wake and schedule run the search wave that moves one cell
// per cycle; other actions go without it.
// One word is worked at a time; the next is taken while a result waits.
// Reset: slot 0 runs with ident 1, all other slots free; effective at once.
module round_robin_task_scheduler import rrts_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam int IW = $clog2(SLOTS);

    fsm_state_t    state_reg, state_next;
    req_word_t     req_reg, req_next;
    logic [IW-1:0] step_reg, step_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [31:0]   counter_reg, counter_next;
    logic          resched_reg, resched_next;
    logic [IW-1:0] res_slot_reg, res_slot_next;
    logic [31:0]   res_ident_reg, res_ident_next;
    logic          res_ok_reg, res_ok_next;
    logic          out_valid_reg, out_valid_next;
    rsp_word_t     out_reg, out_next;

    cell_cmd_t     cmd;
    logic [IW-1:0] sel_idx;
    logic          sel_en;

    carry_t        carry_w [SLOTS];
    logic [IW-1:0] cidx_w  [SLOTS];
    logic [31:0]   ident_w [SLOTS];
    carry_t        best;
    logic [IW-1:0] best_idx;

    assign best     = carry_w[SLOTS-1];
    assign best_idx = cidx_w[SLOTS-1];

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            carry_t        cin;
            logic [IW-1:0] iin;
            if (gi == 0)
            begin : g_first
                assign cin = '0;
                assign iin = '0;
            end
            else
            begin : g_next
                assign cin = carry_w[gi-1];
                assign iin = cidx_w[gi-1];
            end
            rrts_cell #(.SLOTS(SLOTS), .INDEX(gi)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .sel      (sel_en && (sel_idx == IW'(gi))),
                .is_cur   (cur_reg == IW'(gi)),
                .scan_en  ((state_reg == ST_SCAN) && (step_reg == IW'(gi))),
                .carry_in (cin),
                .idx_in   (iin),
                .carry_out(carry_w[gi]),
                .idx_out  (cidx_w[gi]),
                .ident    (ident_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        step_next      = step_reg;
        cur_next       = cur_reg;
        counter_next   = counter_reg;
        resched_next   = resched_reg;
        res_slot_next  = res_slot_reg;
        res_ident_next = res_ident_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sel_idx        = best_idx;
        sel_en         = 1'b0;

        cmd.op         = OP_NONE;
        cmd.wait_kind  = req_reg.wait_kind;
        cmd.wake_value = req_reg.wake_value;
        cmd.channel    = req_reg.channel_id;
        cmd.wake_all   = req_reg.wake_all;
        cmd.exit_id    = req_reg.exit_id;
        cmd.now_tick   = req_reg.now_tick;
        cmd.new_ident  = counter_reg;
        cmd.cur_ident  = ident_w[cur_reg];
        case (req_reg.action)
            ACT_CREATE:    cmd.scan_kind = SK_FREE;
            ACT_WAKE_CHAN: cmd.scan_kind = SK_CHAN;
            default:       cmd.scan_kind = SK_READY;
        endcase

        if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next       = req;
                    step_next      = '0;
                    res_slot_next  = '0;
                    res_ident_next = '0;
                    res_ok_next    = 1'b0;
                    case (req.action)
                        ACT_CREATE:    state_next = ST_SCAN;
                        ACT_WAKE_CHAN: state_next = ST_SCAN;
                        ACT_SCHEDULE:  state_next = ST_PREP;
                        default:       state_next = ST_EXEC;
                    endcase
                end
            end
            ST_PREP:
            begin
                // timers, current task back to ready, reap zombies
                cmd.op     = OP_PREP;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.op    = OP_SCAN;
                step_next = step_reg + 1'b1;
                if (step_reg == IW'(SLOTS - 1))
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (req_reg.action)
                    ACT_CREATE:
                    begin
                        if (best.found && counter_reg != IDENT_MAX)
                        begin
                            cmd.op         = OP_NEW;
                            sel_en         = 1'b1;
                            res_slot_next  = best_idx;
                            res_ident_next = counter_reg;
                            res_ok_next    = 1'b1;
                            counter_next   = counter_reg + 32'd1;
                        end
                    end
                    ACT_BLOCK:
                    begin
                        cmd.op       = OP_BLOCK;
                        resched_next = 1'b1;
                    end
                    ACT_BLOCK_CHAN:
                    begin
                        if (req_reg.channel_id != '0)
                        begin
                            cmd.op       = OP_BLOCK_CHAN;
                            resched_next = 1'b1;
                        end
                    end
                    ACT_WAKE_CHAN:
                    begin
                        if (req_reg.channel_id != '0)
                        begin
                            cmd.op = OP_WAKE_CHAN;
                            sel_en = best.found;
                        end
                    end
                    ACT_WAKE_INPUT:
                    begin
                        cmd.op = OP_WAKE_INPUT;
                    end
                    ACT_TERMINATE:
                    begin
                        cmd.op       = OP_TERMINATE;
                        resched_next = 1'b1;
                    end
                    ACT_SCHEDULE:
                    begin
                        resched_next = 1'b0;
                        if (best.found)
                        begin
                            cmd.op         = OP_RUN;
                            sel_en         = 1'b1;
                            cur_next       = best_idx;
                            res_slot_next  = best_idx;
                            res_ident_next = best.key[31:0];
                            res_ok_next    = 1'b1;
                        end
                        else
                        begin
                            cmd.op         = OP_RESTORE;
                            res_slot_next  = cur_reg;
                            res_ident_next = ident_w[cur_reg];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_next.slot_index      = 4'(res_slot_reg);
                    out_next.task_ident      = res_ident_reg;
                    out_next.success         = res_ok_reg;
                    out_next.running_slot    = 4'(cur_reg);
                    out_next.resched_pending = resched_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cur_reg       <= '0;
            counter_reg   <= IDENT_START;
            resched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cur_reg       <= cur_next;
            counter_reg   <= counter_next;
            resched_reg   <= resched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_slot_reg  <= res_slot_next;
        res_ident_reg <= res_ident_next;
        res_ok_reg    <= res_ok_next;
        out_reg       <= out_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

>>> tb/round_robin_task_scheduler_checker.sv
// Checker for the round-robin task scheduler: watches both channels, predicts each
// result word from its own copy of the slot table and compares in order.
// Depends on rrts_pkg.
`timescale 1ns / 1ps

module round_robin_task_scheduler_checker import rrts_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_word_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_word_t rsp,
    output int        fail_count,
    output int        pending
);

    localparam int LIST_END = SLOTS;

    slot_status_t slot_state [SLOTS];
    logic [31:0]  slot_id    [SLOTS];
    logic [1:0]   slot_kind  [SLOTS];
    logic [63:0]  slot_wake  [SLOTS];
    logic [15:0]  slot_chan  [SLOTS];
    int           slot_next  [SLOTS];
    int           head_slot;
    int           run_slot;
    logic [31:0]  id_counter;
    logic         resched;

    rsp_word_t    expected_q [$];

    function automatic void clear_slot(int s);
        slot_state[s] = SLOT_ZOMBIE;
        slot_id[s]    = '0;
        slot_kind[s]  = WK_NONE;
        slot_wake[s]  = '0;
        slot_chan[s]  = '0;
        slot_next[s]  = LIST_END;
    endfunction

    // Unlink and free every zombie except the kept slot.
    function automatic void prune_zombies(int keep);
        int prev;
        int t;
        int nx;
        int steps;
        prev  = LIST_END;
        t     = head_slot;
        steps = 0;
        while (t < LIST_END && steps < SLOTS)
        begin
            nx = slot_next[t];
            if (t != keep && slot_state[t] == SLOT_ZOMBIE && slot_id[t] != 0)
            begin
                if (prev < LIST_END)
                    slot_next[prev] = nx;
                else
                    head_slot = nx;
                clear_slot(t);
            end
            else
            begin
                prev = t;
            end
            t = nx;
            steps++;
        end
    endfunction

    function automatic rsp_word_t schedule_word(req_word_t w);
        rsp_word_t r;
        int        cur;
        int        s;
        int        t;
        int        steps;
        int        nx;
        r   = '0;
        cur = run_slot;
        case (w.action)
            ACT_CREATE:
            begin
                s = LIST_END;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_id[i] == 0 && s == LIST_END)
                        s = i;
                if (s < LIST_END && id_counter != IDENT_MAX)
                begin
                    clear_slot(s);
                    slot_id[s]    = id_counter;
                    id_counter    = id_counter + 1;
                    slot_state[s] = SLOT_READY;
                    if (head_slot >= LIST_END)
                    begin
                        head_slot = s;
                    end
                    else
                    begin
                        t     = head_slot;
                        steps = 0;
                        while (slot_next[t] < LIST_END && steps < SLOTS)
                        begin
                            t = slot_next[t];
                            steps++;
                        end
                        slot_next[t] = s;
                    end
                    r.slot_index = s[3:0];
                    r.task_ident = slot_id[s];
                    r.success    = 1'b1;
                end
            end
            ACT_BLOCK:
            begin
                slot_kind[cur]  = w.wait_kind;
                slot_wake[cur]  = w.wake_value;
                slot_state[cur] = SLOT_BLOCKED;
                resched         = 1'b1;
            end
            ACT_BLOCK_CHAN:
            begin
                if (w.channel_id != 0)
                begin
                    slot_chan[cur]  = w.channel_id;
                    slot_state[cur] = SLOT_BLOCKED;
                    resched         = 1'b1;
                end
            end
            ACT_WAKE_CHAN:
            begin
                if (w.channel_id != 0)
                begin
                    t     = head_slot;
                    steps = 0;
                    while (t < LIST_END && steps < SLOTS)
                    begin
                        if (slot_state[t] == SLOT_BLOCKED && slot_chan[t] == w.channel_id)
                        begin
                            slot_chan[t]  = '0;
                            slot_state[t] = SLOT_READY;
                            if (!w.wake_all)
                                break;
                        end
                        t = slot_next[t];
                        steps++;
                    end
                end
            end
            ACT_WAKE_INPUT:
            begin
                t     = head_slot;
                steps = 0;
                while (t < LIST_END && steps < SLOTS)
                begin
                    if (slot_state[t] == SLOT_BLOCKED && slot_kind[t] == WK_INPUT)
                    begin
                        slot_kind[t]  = WK_NONE;
                        slot_state[t] = SLOT_READY;
                    end
                    t = slot_next[t];
                    steps++;
                end
            end
            ACT_TERMINATE:
            begin
                slot_state[cur] = SLOT_ZOMBIE;
                t     = head_slot;
                steps = 0;
                while (t < LIST_END && steps < SLOTS)
                begin
                    if (slot_state[t] == SLOT_BLOCKED && slot_kind[t] == WK_CHILD &&
                        slot_wake[t] == w.exit_id)
                    begin
                        slot_kind[t]  = WK_NONE;
                        slot_state[t] = SLOT_READY;
                    end
                    t = slot_next[t];
                    steps++;
                end
                resched = 1'b1;
            end
            ACT_SCHEDULE:
            begin
                resched      = 1'b0;
                r.slot_index = cur[3:0];
                r.task_ident = slot_id[cur];
                if (head_slot < LIST_END)
                begin
                    t     = head_slot;
                    steps = 0;
                    while (t < LIST_END && steps < SLOTS)
                    begin
                        if (slot_state[t] == SLOT_BLOCKED && slot_kind[t] == WK_TIMER &&
                            w.now_tick >= slot_wake[t])
                        begin
                            slot_kind[t]  = WK_NONE;
                            slot_state[t] = SLOT_READY;
                        end
                        t = slot_next[t];
                        steps++;
                    end
                    if (slot_state[cur] == SLOT_RUNNING)
                        slot_state[cur] = SLOT_READY;
                    prune_zombies(cur);
                    nx    = (slot_next[cur] < LIST_END) ? slot_next[cur] : head_slot;
                    steps = 0;
                    while (nx < LIST_END && slot_state[nx] != SLOT_READY && steps < SLOTS)
                    begin
                        nx = (slot_next[nx] < LIST_END) ? slot_next[nx] : head_slot;
                        steps++;
                    end
                    if (nx >= LIST_END || slot_state[nx] != SLOT_READY)
                    begin
                        // nothing ready: keep the current task
                        if (slot_state[cur] != SLOT_ZOMBIE)
                            slot_state[cur] = SLOT_RUNNING;
                    end
                    else
                    begin
                        slot_state[nx] = SLOT_RUNNING;
                        run_slot       = nx;
                        r.slot_index   = nx[3:0];
                        r.task_ident   = slot_id[nx];
                        r.success      = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.running_slot    = run_slot[3:0];
        r.resched_pending = resched;
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            clear_slot(i);
        slot_state[0] = SLOT_RUNNING;
        slot_id[0]    = IDENT_FIRST;
        head_slot     = 0;
        run_slot      = 0;
        id_counter    = IDENT_START;
        resched       = 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word %h", rsp);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.slot_index != want.slot_index ||
                        rsp.task_ident != want.task_ident ||
                        rsp.success != want.success ||
                        rsp.running_slot != want.running_slot ||
                        rsp.resched_pending != want.resched_pending)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result mismatch: slot %0d/%0d ident %h/%h ok %b/%b",
                                      " run %0d/%0d resched %b/%b (exp/got)"},
                                     want.slot_index, rsp.slot_index,
                                     want.task_ident, rsp.task_ident,
                                     want.success, rsp.success,
                                     want.running_slot, rsp.running_slot,
                                     want.resched_pending, rsp.resched_pending);
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_q.push_back(schedule_word(req));
            pending = expected_q.size();
        end
        else
        begin
            fail_count = 0;
            pending    = 0;
        end
    end

endmodule

>>> tb/round_robin_task_scheduler_tb.sv
// Top of the scheduler testbench: clock, reset, request stimulus, result stalls,
// watchdog and verdict. Depends on rrts_pkg, the scheduler and its checker.
`timescale 1ns / 1ps

module round_robin_task_scheduler_tb import rrts_pkg::*;;

    localparam int SLOTS       = 16;
    localparam int PHASE_WORDS = 195;
    localparam int STALL_LIMIT = 20000;

    // action code with no meaning; the block must leave its state alone
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    int          fail_count;
    int          pending;
    int          send_idle = 0;
    int          recv_stall = 0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    int          quiet_cycles = 0;
    logic [63:0] tick_now = 64'd0;

    always #1 clk = ~clk;

    round_robin_task_scheduler #(.SLOTS(SLOTS)) uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    round_robin_task_scheduler_checker #(.SLOTS(SLOTS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    // Result side: random stalls, plus one long hold-off to back up the block.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                for (int i = 0; i < 400; i++)
                begin
                    rsp_stall <= 1'b1;
                    @(posedge clk);
                end
                hold_done = 1'b1;
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input req_word_t w);
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    function automatic req_word_t make_word(input logic [2:0] act, input logic [1:0] kind,
                                            input logic [63:0] wval, input logic [15:0] chan,
                                            input logic all, input logic [63:0] xid,
                                            input logic [63:0] tnow);
        req_word_t w;
        w.action     = act;
        w.wait_kind  = kind;
        w.wake_value = wval;
        w.channel_id = chan;
        w.wake_all   = all;
        w.exit_id    = xid;
        w.now_tick   = tnow;
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed actions on a small id and channel space so waits get matched.
    function automatic req_word_t random_word();
        req_word_t   w;
        int          pick;
        logic [2:0]  act;
        bit          noisy;
        pick  = $urandom_range(0, 99);
        noisy = ($urandom_range(0, 19) == 0);
        if (pick < 20)      act = ACT_CREATE;
        else if (pick < 32) act = ACT_BLOCK;
        else if (pick < 43) act = ACT_BLOCK_CHAN;
        else if (pick < 54) act = ACT_WAKE_CHAN;
        else if (pick < 62) act = ACT_WAKE_INPUT;
        else if (pick < 70) act = ACT_TERMINATE;
        else if (pick < 98) act = ACT_SCHEDULE;
        else                act = ACT_UNUSED;
        w = make_word(act, 2'($urandom_range(0, 3)), 64'd0, 16'($urandom_range(0, 4)),
                      1'($urandom_range(0, 1)), 64'($urandom_range(1, 40)), tick_now);
        if (w.wait_kind == WK_TIMER)
            w.wake_value = tick_now + 64'($urandom_range(0, 60));
        else
            w.wake_value = 64'($urandom_range(1, 40));
        if (noisy)
        begin
            w.wake_value = rand64();
            w.exit_id    = rand64();
            w.now_tick   = rand64();
            w.channel_id = 16'($urandom_range(0, 65535));
        end
        return w;
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_word(ACT_CREATE, WK_NONE, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_CREATE, WK_NONE, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_CREATE, WK_NONE, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_BLOCK, WK_TIMER, 64'd5, 0, 0, 0, 0));
        send_word(make_word(ACT_SCHEDULE, WK_NONE, 0, 0, 0, 0, 64'd1));
        send_word(make_word(ACT_BLOCK, WK_INPUT, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_SCHEDULE, WK_NONE, 0, 0, 0, 0, 64'd2));
        send_word(make_word(ACT_BLOCK_CHAN, WK_NONE, 0, 16'd0, 0, 0, 0));
        send_word(make_word(ACT_BLOCK_CHAN, WK_NONE, 0, 16'hFFFF, 0, 0, 0));
        send_word(make_word(ACT_SCHEDULE, WK_NONE, 0, 0, 0, 0, 64'd3));
        send_word(make_word(ACT_BLOCK, WK_CHILD, 64'd4, 0, 0, 0, 0));
        send_word(make_word(ACT_SCHEDULE, WK_NONE, 0, 0, 0, 0, 64'd4));
        send_word(make_word(ACT_WAKE_CHAN, WK_NONE, 0, 16'd0, 1, 0, 0));
        send_word(make_word(ACT_WAKE_CHAN, WK_NONE, 0, 16'hFFFF, 1, 0, 0));
        send_word(make_word(ACT_WAKE_INPUT, WK_NONE, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_TERMINATE, WK_NONE, 0, 0, 0, 64'd4, 0));
        send_word(make_word(ACT_SCHEDULE, WK_NONE, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        send_word(make_word(ACT_UNUSED, WK_CHILD, '1, '1, 1, '1, '1));
        send_word(make_word(ACT_BLOCK, WK_NONE, '1, 0, 0, 0, 0));
        send_word(make_word(ACT_TERMINATE, WK_NONE, 0, 0, 0, '1, 0));
        send_word(make_word(ACT_SCHEDULE, WK_NONE, 0, 0, 0, 0, 64'd0));
        send_word(make_word(ACT_SCHEDULE, WK_NONE, 0, 0, 0, 0, 64'd0));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 0;  recv_stall = 0;  hold_go = 1'b1;
                end
                1:
                begin
                    send_idle = 74; recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;  recv_stall = 74;
                end
                default:
                begin
                    send_idle = 28; recv_stall = 28;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                tick_now = tick_now + 64'($urandom_range(0, 20));
                send_word(random_word());
            end
        end
        req_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
